@@ src/rc_channel_frame_packer_top_defines.svh @@
// Assertion macros used by the channel frame packer serializer.
`ifndef RC_CHANNEL_FRAME_PACKER_TOP_DEFINES_SVH
`define RC_CHANNEL_FRAME_PACKER_TOP_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define RCFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcfp assertion failed");

// Checks that cons holds in the cycle after ante.
`define RCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcfp assertion failed");

`endif

@@ src/rcfp_pkg.sv @@
// Types, constants and helper functions of the channel frame packer.
package rcfp_pkg;

    localparam int FRAME_BYTES = 12;
    localparam int NUM_STAGES  = 5;
    localparam int SAMPLE_W    = 12;
    localparam int SCALED_W    = 10;

    localparam logic [15:0] MID_VALUE   = 16'd1500;
    localparam logic [15:0] OFFSET_BASE = 16'd2500;
    localparam logic [9:0]  SCALE_GAIN  = 10'd1000;
    localparam logic [7:0]  SEQ_LIMIT   = 8'd200;
    localparam logic [7:0]  FRAME_TRAILER = 8'hA5;

    localparam logic [15:0] RST_CENTER    = 16'd1500;
    localparam logic [10:0] RST_DEAD_LOW  = 11'd1470;
    localparam logic [15:0] RST_DEAD_HIGH = 16'd1530;
    localparam logic [15:0] RST_SHIFT     = 16'd30;
    localparam logic [15:0] RST_CLAMP_MIN = 16'd1100;
    localparam logic [15:0] RST_CLAMP_MAX = 16'd1900;

    typedef enum logic [2:0] {
        REG_YAW_CENTER   = 3'd0,
        REG_ROLL_CENTER  = 3'd1,
        REG_PITCH_CENTER = 3'd2,
        REG_DEAD_LOW     = 3'd3,
        REG_DEAD_HIGH    = 3'd4,
        REG_CLAMP_MIN    = 3'd5,
        REG_CLAMP_MAX    = 3'd6
    } cfg_reg_t;

    // Settings shared by all conditioned lanes; shift is 1500 minus dead_low.
    typedef struct packed {
        logic [10:0] dead_low;
        logic [15:0] dead_high;
        logic [15:0] shift;
        logic [15:0] clamp_min;
        logic [15:0] clamp_max;
    } cond_cfg_t;

    // Frame fields that travel beside the lanes.
    typedef struct packed {
        logic [7:0]          lead;
        logic [7:0]          mask;
        logic [7:0]          seq;
        logic [SCALED_W-1:0] throttle;
    } side_t;

    // sample * 1000 >> 12, at most 999.
    function automatic logic [SCALED_W-1:0] scale_sample(logic [SAMPLE_W-1:0] s);
        logic [21:0] prod;
        prod = 22'(s) * 22'(SCALE_GAIN);
        return prod[21:12];
    endfunction

endpackage

@@ src/rcfp_lane.sv @@
// One stick channel lane: scaling, offset, deadband and clamp in five stages.
module rcfp_lane
    import rcfp_pkg::*;
(
    input  logic                clk,
    input  logic                adv,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [15:0]         center,
    input  cond_cfg_t           cfg,
    output logic [15:0]         chan
);

    logic [SCALED_W-1:0] s1_reg, s1_next;
    logic [15:0] v0_reg, v0_next;
    logic [15:0] v2_reg, v2_next;
    logic [15:0] v3_reg, v3_next;
    logic [15:0] chan_reg, chan_next;
    logic [15:0] dl_ext;
    logic [15:0] v1;
    logic [15:0] v4;

    assign dl_ext = {5'd0, cfg.dead_low};

    always_comb
    begin
        s1_next = scale_sample(sample);
        v0_next = OFFSET_BASE + 16'(s1_reg) - center;

        // Inside the band snaps to mid; below the lower edge is shifted up.
        v1 = ((v0_reg > dl_ext) && (v0_reg < cfg.dead_high)) ? MID_VALUE : v0_reg;
        v2_next = (v1 < dl_ext) ? v1 + cfg.shift : v1;

        v3_next = (v2_reg > cfg.dead_high) ? v2_reg - cfg.shift : v2_reg;

        // With crossed limits the upper limit wins.
        v4 = (v3_reg <= cfg.clamp_min) ? cfg.clamp_min : v3_reg;
        chan_next = (v4 >= cfg.clamp_max) ? cfg.clamp_max : v4;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg   <= s1_next;
            v0_reg   <= v0_next;
            v2_reg   <= v2_next;
            v3_reg   <= v3_next;
            chan_reg <= chan_next;
        end
    end

    assign chan = chan_reg;

endmodule

@@ src/rcfp_serializer.sv @@
// Frame buffer that sends a finished frame one word per cycle while m_tready is high.
module rcfp_serializer
    import rcfp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load_valid,
    output logic                     load_ready,
    input  logic [FRAME_BYTES*8-1:0] frame,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,
    output logic                     m_tlast
);

    `include "rc_channel_frame_packer_top_defines.svh"

    localparam logic [3:0] LAST_IDX = 4'(FRAME_BYTES - 1);

    logic [FRAME_BYTES*8-1:0] frame_reg, frame_next;
    logic [3:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic take;
    logic load;

    assign take       = busy_reg && m_tready;
    assign load_ready = !busy_reg || (take && (cnt_reg == LAST_IDX));
    assign load       = load_valid && load_ready;

    always_comb
    begin
        frame_next = frame_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (load)
        begin
            frame_next = frame;
            cnt_next   = 4'd0;
            busy_next  = 1'b1;
        end
        else if (take)
        begin
            frame_next = frame_reg >> 8;
            cnt_next   = cnt_reg + 4'd1;
            if (cnt_reg == LAST_IDX)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 4'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = frame_reg[7:0];
    assign m_tlast  = (cnt_reg == LAST_IDX);

    `RCFP_ASSERT_SAME(a_trailer_last, clk, rst_n, m_tvalid && m_tlast, m_tdata == FRAME_TRAILER)
    `RCFP_ASSERT_NEXT(a_load_starts, clk, rst_n, load, m_tvalid && !m_tlast)
    `RCFP_ASSERT_NEXT(a_drain_idle, clk, rst_n, take && m_tlast && !load_valid, !m_tvalid)
    `RCFP_ASSERT_SAME(a_load_only_at_end, clk, rst_n, load && busy_reg, take && m_tlast)

endmodule

@@ src/rc_channel_frame_packer_top.sv @@
// Top level of the radio control channel frame packer.
// Usage: a request word on the s_axis channel carries the lead byte, the button
// mask and four 12-bit stick samples (yaw, throttle, roll, pitch). For each
// accepted request the block sends a 12-word frame on the m_axis channel: lead,
// mask, yaw, throttle, roll and pitch little-endian, the sequence count and the
// 0xA5 trailer, with tlast on the trailer. Yaw, roll and pitch run through three
// identical lanes (scale, offset, deadband, clamp); throttle is only scaled.
// The first frame word is offered once the request has passed every lane stage
// and has been loaded into the frame buffer. The output rate is set by the
// single byte-wide output port; the lanes take a new request every cycle while
// their last stage is not waiting, and hold up to five requests in flight.
// When the receiver stalls, the frame buffer holds its word, the lane pipeline
// fills behind it and s_axis_tready drops once the last lane stage is waiting.
// The cfg channel writes the seven calibration registers (index 0 to 6); it is
// always ready and must only be used while the block is idle. Index 7 is ignored.
// Reset (rst_n low, asynchronous) empties the pipeline and the frame buffer,
// restores the register defaults and clears the sequence count.
module rc_channel_frame_packer_top
    import rcfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Request words.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: lead_byte[7:0], button_bits[15:8], yaw_sample[27:16],
    // throttle_sample[39:28], roll_sample[51:40], pitch_sample[63:52].
    input  logic [63:0] s_axis_tdata,
    // Frame words.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: frame_byte[7:0].
    output logic [7:0]  m_axis_tdata,
    // tlast: frame_last, set on the trailer word.
    output logic        m_axis_tlast,
    // Register writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] yaw_center_reg;
    logic [15:0] roll_center_reg;
    logic [15:0] pitch_center_reg;
    cond_cfg_t   cond_cfg_reg;

    logic [7:0] seq_reg, seq_next;
    logic [7:0] seq_inc;

    logic [NUM_STAGES-1:0] vld_reg, vld_next;
    side_t side_reg [NUM_STAGES];

    logic adv;
    logic accept;
    logic load_ready;
    logic [15:0] yaw_chan;
    logic [15:0] roll_chan;
    logic [15:0] pitch_chan;
    logic [FRAME_BYTES*8-1:0] frame;
    side_t side_last;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_center_reg         <= RST_CENTER;
            roll_center_reg        <= RST_CENTER;
            pitch_center_reg       <= RST_CENTER;
            cond_cfg_reg.dead_low  <= RST_DEAD_LOW;
            cond_cfg_reg.dead_high <= RST_DEAD_HIGH;
            cond_cfg_reg.shift     <= RST_SHIFT;
            cond_cfg_reg.clamp_min <= RST_CLAMP_MIN;
            cond_cfg_reg.clamp_max <= RST_CLAMP_MAX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_YAW_CENTER:   yaw_center_reg   <= cfg_data;
                REG_ROLL_CENTER:  roll_center_reg  <= cfg_data;
                REG_PITCH_CENTER: pitch_center_reg <= cfg_data;
                REG_DEAD_LOW:
                begin
                    cond_cfg_reg.dead_low <= cfg_data[10:0];
                    // The shift is kept ready so that the lanes need no subtract for it.
                    cond_cfg_reg.shift    <= MID_VALUE - {5'd0, cfg_data[10:0]};
                end
                REG_DEAD_HIGH:    cond_cfg_reg.dead_high <= cfg_data;
                REG_CLAMP_MIN:    cond_cfg_reg.clamp_min <= cfg_data;
                REG_CLAMP_MAX:    cond_cfg_reg.clamp_max <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The whole lane pipeline moves together; it stops only when the last
    // stage holds a frame that the buffer cannot take yet.
    assign adv           = !vld_reg[NUM_STAGES-1] || load_ready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    // Sequence count 1..200, then back to 0; each frame carries the new value.
    assign seq_inc  = (seq_reg >= SEQ_LIMIT) ? 8'd0 : seq_reg + 8'd1;
    assign seq_next = accept ? seq_inc : seq_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (adv)
        begin
            vld_next = {vld_reg[NUM_STAGES-2:0], accept};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= 8'd0;
            vld_reg <= '0;
        end
        else
        begin
            seq_reg <= seq_next;
            vld_reg <= vld_next;
        end
    end

    // Side fields travel in step with the lanes.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].lead     <= s_axis_tdata[7:0];
            side_reg[0].mask     <= s_axis_tdata[15:8];
            side_reg[0].seq      <= seq_inc;
            side_reg[0].throttle <= scale_sample(s_axis_tdata[39:28]);
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    rcfp_lane u_yaw_lane (
        .clk    (clk),
        .adv    (adv),
        .sample (s_axis_tdata[27:16]),
        .center (yaw_center_reg),
        .cfg    (cond_cfg_reg),
        .chan   (yaw_chan)
    );

    rcfp_lane u_roll_lane (
        .clk    (clk),
        .adv    (adv),
        .sample (s_axis_tdata[51:40]),
        .center (roll_center_reg),
        .cfg    (cond_cfg_reg),
        .chan   (roll_chan)
    );

    rcfp_lane u_pitch_lane (
        .clk    (clk),
        .adv    (adv),
        .sample (s_axis_tdata[63:52]),
        .center (pitch_center_reg),
        .cfg    (cond_cfg_reg),
        .chan   (pitch_chan)
    );

    // Merge the lane results into the frame, first word in the low byte.
    assign side_last = side_reg[NUM_STAGES-1];
    assign frame = {
        FRAME_TRAILER,
        side_last.seq,
        pitch_chan[15:8], pitch_chan[7:0],
        roll_chan[15:8],  roll_chan[7:0],
        {6'd0, side_last.throttle[9:8]}, side_last.throttle[7:0],
        yaw_chan[15:8],   yaw_chan[7:0],
        side_last.mask,
        side_last.lead
    };

    rcfp_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (vld_reg[NUM_STAGES-1]),
        .load_ready (load_ready),
        .frame      (frame),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tlast    (m_axis_tlast)
    );

endmodule
